// ===== rtl/olist_pkg.sv =====
// Shared types and constants for the ordered list engine.
// No dependencies; used by olist_ctrl and ordered_list_engine_unit.
`default_nettype none
package olist_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 11;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND     = 3'd0,
    FN_PREPEND    = 3'd1,
    FN_INSERT_AT  = 3'd2,
    FN_REMOVE_VAL = 3'd3,
    FN_REMOVE_AT  = 3'd4,
    FN_FIND_VAL   = 3'd5,
    FN_READ_AT    = 3'd6
  } func_t;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_RD_WAIT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/ordered_list_engine_unit.sv =====
// Ordered list engine top level: sequencer plus element RAM.
// Depends on olist_pkg, olist_ctrl and olist_ram.
//
// One request is taken when start is high and busy is low. Its single result appears on the
// out_ ports for one cycle with out_valid high, and the receiver cannot hold it off. A scan or
// shift walks the element RAM one entry per cycle through its single read port.
// Each kind of request runs as follows:
// - a rejected request (full list, position out of range, unused code) answers from idle;
// - a read at a position reads that entry and then answers;
// - an insert moves each element from the tail down to its position one slot up, then writes
//   the new value and answers;
// - a remove at a position moves each element after it one slot down, then answers;
// - a find scans from the head and answers at the first match, or as a miss at the end;
// - a remove by value is that scan followed by the shift down past the match, and a miss
//   answers as for a find.
// busy drops in the cycle the result is shown, so the next request can be taken then.
`default_nettype none
module ordered_list_engine_unit #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [olist_pkg::FUNC_W-1:0]        in_func,
  input  wire logic signed [olist_pkg::DATA_W-1:0] in_item_value,
  input  wire logic [olist_pkg::POS_W-1:0]         in_position,
  output logic                                     out_valid,
  output logic [olist_pkg::STATUS_W-1:0]           out_status,
  output logic signed [olist_pkg::DATA_W-1:0]      out_found_value,
  output logic [olist_pkg::LEN_W-1:0]              out_list_length
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [olist_pkg::DATA_W-1:0] wr_data;
  logic [AW-1:0]                rd_addr;
  logic [olist_pkg::DATA_W-1:0] rd_data;
  logic [olist_pkg::DATA_W-1:0] found_value;

  assign out_found_value = found_value;

  olist_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_item_value     (in_item_value),
    .in_position       (in_position),
    .out_valid_r       (out_valid),
    .out_status_r      (out_status),
    .out_found_value_r (found_value),
    .out_list_length_r (out_list_length),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data)
  );

  olist_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (olist_pkg::DATA_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

endmodule
`default_nettype wire

// ===== rtl/olist_ram.sv =====
// Element store: simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none
module olist_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data_r
);

  logic [DW-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/olist_ctrl.sv =====
// Sequencer for the ordered list engine: element count, scan and shift walks over the RAM.
// Depends on olist_pkg; drives one olist_ram instance.
`default_nettype none
module olist_ctrl #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned AW       = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [olist_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [olist_pkg::DATA_W-1:0]      in_item_value,
  input  wire logic [olist_pkg::POS_W-1:0]       in_position,
  output logic                                   out_valid_r,
  output logic [olist_pkg::STATUS_W-1:0]         out_status_r,
  output logic [olist_pkg::DATA_W-1:0]           out_found_value_r,
  output logic [olist_pkg::LEN_W-1:0]            out_list_length_r,
  output logic                                   wr_en,
  output logic [AW-1:0]                          wr_addr,
  output logic [olist_pkg::DATA_W-1:0]           wr_data,
  output logic [AW-1:0]                          rd_addr,
  input  wire logic [olist_pkg::DATA_W-1:0]      rd_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > olist_pkg::POS_W) ? CW : olist_pkg::POS_W;

  olist_pkg::state_t state_r, state_nxt;
  logic [olist_pkg::FUNC_W-1:0] op_r, op_nxt;
  logic [olist_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [CW-1:0] tgt_r, tgt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_nxt;
  logic [olist_pkg::STATUS_W-1:0] out_status_nxt;
  logic [olist_pkg::DATA_W-1:0]   out_found_value_nxt;
  logic [olist_pkg::LEN_W-1:0]    out_list_length_nxt;
  logic          rd_issue;
  logic          pos_in_list;
  logic [CW-1:0] ins_where;

  assign busy = (state_r != olist_pkg::S_IDLE);
  assign pos_in_list = XW'(in_position) < XW'(count_r);
  assign ins_where = pos_in_list ? CW'(in_position) : count_r;

  always_comb begin
    state_nxt           = state_r;
    op_nxt              = op_r;
    val_nxt             = val_r;
    tgt_nxt             = tgt_r;
    idx_nxt             = idx_r;
    wa_nxt              = wa_r;
    pend_nxt            = pend_r;
    count_nxt           = count_r;
    out_valid_nxt       = 1'b0;
    out_status_nxt      = out_status_r;
    out_found_value_nxt = out_found_value_r;
    out_list_length_nxt = out_list_length_r;
    wr_en               = 1'b0;
    wr_addr             = wa_r;
    wr_data             = rd_data;
    rd_addr             = AW'(idx_r);
    rd_issue            = 1'b0;

    case (state_r)
      olist_pkg::S_IDLE: begin
        if (start) begin
          op_nxt   = in_func;
          val_nxt  = in_item_value;
          pend_nxt = 1'b0;
          case (in_func)
            olist_pkg::FN_APPEND, olist_pkg::FN_PREPEND, olist_pkg::FN_INSERT_AT: begin
              if (count_r == CW'(CAPACITY)) begin
                out_valid_nxt       = 1'b1;
                out_status_nxt      = olist_pkg::ST_FULL;
                out_found_value_nxt = '0;
                out_list_length_nxt = olist_pkg::LEN_W'(count_r);
              end else begin
                if (in_func == olist_pkg::FN_APPEND) begin
                  tgt_nxt = count_r;
                end else if (in_func == olist_pkg::FN_PREPEND) begin
                  tgt_nxt = '0;
                end else begin
                  tgt_nxt = ins_where;
                end
                idx_nxt   = count_r;
                state_nxt = olist_pkg::S_SHIFT_UP;
              end
            end
            olist_pkg::FN_REMOVE_VAL, olist_pkg::FN_FIND_VAL: begin
              idx_nxt   = '0;
              state_nxt = olist_pkg::S_SCAN;
            end
            olist_pkg::FN_REMOVE_AT: begin
              if (pos_in_list) begin
                idx_nxt   = CW'(in_position) + CW'(1);
                state_nxt = olist_pkg::S_SHIFT_DN;
              end else begin
                out_valid_nxt       = 1'b1;
                out_status_nxt      = olist_pkg::ST_NONE;
                out_found_value_nxt = '0;
                out_list_length_nxt = olist_pkg::LEN_W'(count_r);
              end
            end
            olist_pkg::FN_READ_AT: begin
              if (pos_in_list) begin
                rd_addr   = AW'(in_position);
                state_nxt = olist_pkg::S_RD_WAIT;
              end else begin
                out_valid_nxt       = 1'b1;
                out_status_nxt      = olist_pkg::ST_NONE;
                out_found_value_nxt = '0;
                out_list_length_nxt = olist_pkg::LEN_W'(count_r);
              end
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_status_nxt      = olist_pkg::ST_NONE;
              out_found_value_nxt = '0;
              out_list_length_nxt = olist_pkg::LEN_W'(count_r);
            end
          endcase
        end
      end

      olist_pkg::S_SCAN: begin
        if (pend_r && (rd_data == val_r)) begin
          pend_nxt = 1'b0;
          if (op_r == olist_pkg::FN_FIND_VAL) begin
            out_valid_nxt       = 1'b1;
            out_status_nxt      = olist_pkg::ST_OK;
            out_found_value_nxt = rd_data;
            out_list_length_nxt = olist_pkg::LEN_W'(count_r);
            state_nxt           = olist_pkg::S_IDLE;
          end else begin
            idx_nxt   = CW'(wa_r) + CW'(1);
            state_nxt = olist_pkg::S_SHIFT_DN;
          end
        end else if (idx_r < count_r) begin
          rd_issue = 1'b1;
          rd_addr  = AW'(idx_r);
          pend_nxt = 1'b1;
          wa_nxt   = AW'(idx_r);
          idx_nxt  = idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            out_valid_nxt       = 1'b1;
            out_status_nxt      = olist_pkg::ST_NONE;
            out_found_value_nxt = '0;
            out_list_length_nxt = olist_pkg::LEN_W'(count_r);
            state_nxt           = olist_pkg::S_IDLE;
          end
        end
      end

      // walk down from the tail, moving each element one slot up
      olist_pkg::S_SHIFT_UP: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = wa_r;
          wr_data = rd_data;
        end
        if (idx_r > tgt_r) begin
          rd_issue = 1'b1;
          rd_addr  = AW'(idx_r - CW'(1));
          pend_nxt = 1'b1;
          wa_nxt   = AW'(idx_r);
          idx_nxt  = idx_r - CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            wr_en               = 1'b1;
            wr_addr             = AW'(tgt_r);
            wr_data             = val_r;
            count_nxt           = count_r + CW'(1);
            out_valid_nxt       = 1'b1;
            out_status_nxt      = olist_pkg::ST_OK;
            out_found_value_nxt = '0;
            out_list_length_nxt = olist_pkg::LEN_W'(count_r + CW'(1));
            state_nxt           = olist_pkg::S_IDLE;
          end
        end
      end

      // walk up past the removed slot, moving each element one slot down
      olist_pkg::S_SHIFT_DN: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = wa_r;
          wr_data = rd_data;
        end
        if (idx_r < count_r) begin
          rd_issue = 1'b1;
          rd_addr  = AW'(idx_r);
          pend_nxt = 1'b1;
          wa_nxt   = AW'(idx_r - CW'(1));
          idx_nxt  = idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt           = count_r - CW'(1);
            out_valid_nxt       = 1'b1;
            out_status_nxt      = olist_pkg::ST_OK;
            out_found_value_nxt = '0;
            out_list_length_nxt = olist_pkg::LEN_W'(count_r - CW'(1));
            state_nxt           = olist_pkg::S_IDLE;
          end
        end
      end

      olist_pkg::S_RD_WAIT: begin
        out_valid_nxt       = 1'b1;
        out_status_nxt      = olist_pkg::ST_OK;
        out_found_value_nxt = rd_data;
        out_list_length_nxt = olist_pkg::LEN_W'(count_r);
        state_nxt           = olist_pkg::S_IDLE;
      end

      default: begin
        state_nxt = olist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olist_pkg::S_IDLE;
      pend_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r              <= op_nxt;
    val_r             <= val_nxt;
    tgt_r             <= tgt_nxt;
    idx_r             <= idx_nxt;
    wa_r              <= wa_nxt;
    out_status_r      <= out_status_nxt;
    out_found_value_r <= out_found_value_nxt;
    out_list_length_r <= out_list_length_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAPACITY)
    else $error("element count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_issue) |-> (wr_addr != rd_addr))
    else $error("shift walk reads the entry it writes");

  a_count_moves_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> out_valid_r)
    else $error("length changed without a result");

  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == olist_pkg::ST_FULL))
      |-> (out_list_length_r == olist_pkg::LEN_W'(CAPACITY)))
    else $error("full status with list not full");

endmodule
`default_nettype wire
